FILE: rtl/core/lpg_pkg.sv
package lpg_pkg;

  localparam int unsigned FieldWidth = 16;
  localparam int unsigned ColorWidth = 32;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   operation;
    logic [FieldWidth-1:0] start_x;
    logic [FieldWidth-1:0] start_y;
    logic [FieldWidth-1:0] end_x;
    logic [FieldWidth-1:0] end_y;
  } line_in_t;

  typedef struct packed {
    logic [FieldWidth-1:0] pixel_x;
    logic [FieldWidth-1:0] pixel_y;
    logic [ColorWidth-1:0] pixel_color;
    logic                  last_point;
  } pixel_out_t;

endpackage

FILE: rtl/core/lpg_in_stage.sv
module lpg_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpg_pkg::line_in_t in_data_i,
  input  logic              fire_i,
  output logic              valid_o,
  output lpg_pkg::line_in_t data_o
);
  import lpg_pkg::*;

  logic     valid_q, valid_d;
  line_in_t data_q;
  logic     take;

  assign in_stall_o = valid_q && !fire_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/lpg_step.sv
module lpg_step #(
  parameter int unsigned CoordWidth = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  lpg_pkg::line_in_t                   item_i,
  input  logic [lpg_pkg::ColorWidth-1:0]      color_i,
  output logic                                res_valid_o,
  output lpg_pkg::pixel_out_t                 res_o,
  output logic                                busy_o
);
  import lpg_pkg::*;

  localparam int unsigned ErrWidth = CoordWidth + 2;
  localparam int unsigned CntWidth = CoordWidth + 1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_POS  = 2'b01,
    DIR_NEG  = 2'b11
  } dir_e;

  logic [CoordWidth-1:0] cur_x_q, cur_y_q, abs_dx_q, abs_dy_q, major_q;
  logic [ErrWidth-1:0]   err_x_q, err_y_q;
  logic [CntWidth-1:0]   left_q;
  dir_e                  dir_x_q, dir_y_q;
  logic                  busy_q;

  logic [CoordWidth-1:0] cur_x_d, cur_y_d;
  logic [ErrWidth-1:0]   err_x_d, err_y_d;
  logic [CntWidth-1:0]   left_d, left_dec;
  logic                  busy_d;

  logic                  is_start;
  logic [CoordWidth-1:0] sx, sy, ex, ey;
  logic [CoordWidth-1:0] dx_new, dy_new, major_new;
  dir_e                  dir_x_new, dir_y_new;

  logic [CoordWidth-1:0] cur_x_b, cur_y_b, dx_b, dy_b, major_b;
  logic [ErrWidth-1:0]   err_x_b, err_y_b, sum_x, sum_y;
  dir_e                  dir_x_b, dir_y_b;

  function automatic logic [CoordWidth-1:0] apply_dir(logic [CoordWidth-1:0] c, dir_e d);
    logic [CoordWidth-1:0] r;
    case (d)
      DIR_POS: r = c + CoordWidth'(1);
      DIR_NEG: r = c - CoordWidth'(1);
      default: r = c;
    endcase
    return r;
  endfunction

  always_comb begin
    is_start = (item_i.operation == OP_START);
    sx = item_i.start_x[CoordWidth-1:0];
    sy = item_i.start_y[CoordWidth-1:0];
    ex = item_i.end_x[CoordWidth-1:0];
    ey = item_i.end_y[CoordWidth-1:0];

    if (ex > sx) begin
      dx_new = ex - sx;
      dir_x_new = DIR_POS;
    end else if (ex == sx) begin
      dx_new = '0;
      dir_x_new = DIR_NONE;
    end else begin
      dx_new = sx - ex;
      dir_x_new = DIR_NEG;
    end
    if (ey > sy) begin
      dy_new = ey - sy;
      dir_y_new = DIR_POS;
    end else if (ey == sy) begin
      dy_new = '0;
      dir_y_new = DIR_NONE;
    end else begin
      dy_new = sy - ey;
      dir_y_new = DIR_NEG;
    end
    major_new = (dx_new > dy_new) ? dx_new : dy_new;

    // A start item replaces the line state before the first step is taken.
    if (is_start) begin
      cur_x_b = sx;
      cur_y_b = sy;
      dx_b    = dx_new;
      dy_b    = dy_new;
      major_b = major_new;
      err_x_b = '0;
      err_y_b = '0;
      dir_x_b = dir_x_new;
      dir_y_b = dir_y_new;
    end else begin
      cur_x_b = cur_x_q;
      cur_y_b = cur_y_q;
      dx_b    = abs_dx_q;
      dy_b    = abs_dy_q;
      major_b = major_q;
      err_x_b = err_x_q;
      err_y_b = err_y_q;
      dir_x_b = dir_x_q;
      dir_y_b = dir_y_q;
    end

    left_dec = left_q - CntWidth'(1);

    res_valid_o       = is_start || busy_q;
    res_o.pixel_x     = FieldWidth'(cur_x_b);
    res_o.pixel_y     = FieldWidth'(cur_y_b);
    res_o.pixel_color = color_i;
    res_o.last_point  = !is_start && (left_dec == '0);

    sum_x   = err_x_b + ErrWidth'(dx_b);
    sum_y   = err_y_b + ErrWidth'(dy_b);
    err_x_d = sum_x;
    err_y_d = sum_y;
    cur_x_d = cur_x_b;
    cur_y_d = cur_y_b;
    if (sum_x > ErrWidth'(major_b)) begin
      err_x_d = sum_x - ErrWidth'(major_b);
      cur_x_d = apply_dir(cur_x_b, dir_x_b);
    end
    if (sum_y > ErrWidth'(major_b)) begin
      err_y_d = sum_y - ErrWidth'(major_b);
      cur_y_d = apply_dir(cur_y_b, dir_y_b);
    end

    if (is_start) begin
      left_d = {1'b0, major_b} + CntWidth'(1);
      busy_d = 1'b1;
    end else begin
      left_d = left_dec;
      busy_d = (left_dec != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      abs_dx_q <= '0;
      abs_dy_q <= '0;
      major_q  <= '0;
      err_x_q  <= '0;
      err_y_q  <= '0;
      left_q   <= '0;
      dir_x_q  <= DIR_NONE;
      dir_y_q  <= DIR_NONE;
      busy_q   <= 1'b0;
    end else if (fire_i && res_valid_o) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      abs_dx_q <= dx_b;
      abs_dy_q <= dy_b;
      major_q  <= major_b;
      err_x_q  <= err_x_d;
      err_y_q  <= err_y_d;
      left_q   <= left_d;
      dir_x_q  <= dir_x_b;
      dir_y_q  <= dir_y_b;
      busy_q   <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

FILE: rtl/core/lpg_out_stage.sv
module lpg_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lpg_pkg::pixel_out_t data_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpg_pkg::pixel_out_t out_data_o
);
  import lpg_pkg::*;

  logic       valid_q;
  pixel_out_t data_q;

  // The register can take a new result when empty or when its transfer completes now.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/core/line_point_generator_core.sv
// Each item is held in the input register and its result in the result register.
// Throughput: one item per cycle unless the output stalls; each item taken that gives a result
// updates the line state by a single step.
// An advance item while no line is in progress is consumed and gives no result.
// Reset (rst_ni low, asynchronous) empties both registers, clears the line state and sets
// the draw color to zero.
module line_point_generator_core #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lpg_pkg::ColorWidth-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lpg_pkg::line_in_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lpg_pkg::pixel_out_t               out_data_o
);
  import lpg_pkg::*;

  logic                  item_valid;
  line_in_t              item;
  logic                  out_ready;
  logic                  fire;
  logic                  res_valid;
  pixel_out_t            res;
  logic                  busy;
  logic [ColorWidth-1:0] color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_q <= cfg_data_i;
    end
  end

  assign fire = item_valid && out_ready;

  lpg_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .fire_i     (fire),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  lpg_step #(
    .CoordWidth (COORD_WIDTH)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .color_i     (color_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .busy_o      (busy)
  );

  lpg_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .data_i      (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The first point of a new line is never the last one.
  a_start_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (item.operation == OP_START) |=> out_valid_o && !out_data_o.last_point)
    else $error("start item produced a missing or final point");

  // Emitting the final point ends the line.
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_valid && res.last_point |=> !busy)
    else $error("line still in progress after its final point");

  // While a final point waits, no new line has begun.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_point |-> !busy)
    else $error("final point pending while a line is in progress");

endmodule

FILE: tb/sv/line_point_generator_core_tb.sv
module line_point_generator_core_tb;
  import lpg_pkg::*;

  localparam int unsigned CoordW = 16;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxAdvances = 40;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } step_dir_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [ColorWidth-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  line_in_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pixel_out_t            out_data_o;

  wire cfg_fire = cfg_valid_i && cfg_ready_o;
  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  // Predictor state of the line in progress.
  logic [ColorWidth-1:0] color_reg = '0;
  logic [15:0]           ln_x = '0, ln_y = '0;
  logic [15:0]           ln_dx = '0, ln_dy = '0, ln_major = '0;
  step_dir_e             ln_dir_x = DIR_NONE, ln_dir_y = DIR_NONE;
  logic [17:0]           ln_err_x = '0, ln_err_y = '0;
  logic [16:0]           ln_points_left = '0;
  logic                  ln_busy = 1'b0;

  pixel_out_t pixel_q[$];
  int unsigned items_taken = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_request = 1'b0;
  int unsigned hold_left = 0;

  line_point_generator_core #(
    .COORD_WIDTH(CoordW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void axis_delta(input logic [15:0] a, input logic [15:0] b,
                                     output logic [15:0] d, output step_dir_e dir);
    if (b > a) begin
      d = b - a;
      dir = DIR_POS;
    end else if (b == a) begin
      d = '0;
      dir = DIR_NONE;
    end else begin
      d = a - b;
      dir = DIR_NEG;
    end
  endfunction

  function automatic logic [15:0] step_coord(input logic [15:0] c, input step_dir_e dir);
    case (dir)
      DIR_POS: return c + 16'd1;
      DIR_NEG: return c - 16'd1;
      default: return c;
    endcase
  endfunction

  function automatic void step_line();
    ln_err_x = ln_err_x + {2'b00, ln_dx};
    ln_err_y = ln_err_y + {2'b00, ln_dy};
    if (ln_err_x > {2'b00, ln_major}) begin
      ln_err_x = ln_err_x - {2'b00, ln_major};
      ln_x = step_coord(ln_x, ln_dir_x);
    end
    if (ln_err_y > {2'b00, ln_major}) begin
      ln_err_y = ln_err_y - {2'b00, ln_major};
      ln_y = step_coord(ln_y, ln_dir_y);
    end
  endfunction

  function automatic void queue_pixel(input logic last);
    pixel_out_t px;
    px.pixel_x     = ln_x;
    px.pixel_y     = ln_y;
    px.pixel_color = color_reg;
    px.last_point  = last;
    pixel_q.push_back(px);
  endfunction

  function automatic void predict_pixel(input line_in_t item);
    if (item.operation == OP_START) begin
      axis_delta(item.start_x, item.end_x, ln_dx, ln_dir_x);
      axis_delta(item.start_y, item.end_y, ln_dy, ln_dir_y);
      ln_major = (ln_dx > ln_dy) ? ln_dx : ln_dy;
      ln_err_x = '0;
      ln_err_y = '0;
      ln_x = item.start_x;
      ln_y = item.start_y;
      queue_pixel(1'b0);
      step_line();
      ln_points_left = {1'b0, ln_major} + 17'd1;
      ln_busy = 1'b1;
    end else if (ln_busy) begin
      ln_points_left = ln_points_left - 17'd1;
      if (ln_points_left == 17'd0) begin
        queue_pixel(1'b1);
        ln_busy = 1'b0;
      end else begin
        queue_pixel(1'b0);
      end
      step_line();
    end
  endfunction

  // Predict on every input transfer and check every output transfer.
  always @(posedge clk_i) begin : monitor
    pixel_out_t want;
    if (cfg_fire) begin
      color_reg = cfg_data_i;
      cfg_writes++;
    end
    if (in_fire) begin
      predict_pixel(in_data_i);
      items_taken++;
    end
    if (out_fire) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel x=%0h y=%0h", out_data_o.pixel_x, out_data_o.pixel_y);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_data_o.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0h, got %0h", want.pixel_x, out_data_o.pixel_x);
          mismatches++;
        end
        if (out_data_o.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0h, got %0h", want.pixel_y, out_data_o.pixel_y);
          mismatches++;
        end
        if (out_data_o.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %0h, got %0h", want.pixel_color,
                 out_data_o.pixel_color);
          mismatches++;
        end
        if (out_data_o.last_point !== want.last_point) begin
          $error("last_point: expected %0b, got %0b", want.last_point, out_data_o.last_point);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cfg_fire || in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side: random stalls, or one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer, valid still high.
  task automatic send_item(input line_in_t item);
    int unsigned taken_before;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    taken_before = items_taken;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(negedge clk_i); while (items_taken == taken_before);
  endtask

  function automatic line_in_t start_item(input logic [15:0] sx, input logic [15:0] sy,
                                          input logic [15:0] ex, input logic [15:0] ey);
    line_in_t item;
    item.operation = OP_START;
    item.start_x = sx;
    item.start_y = sy;
    item.end_x = ex;
    item.end_y = ey;
    return item;
  endfunction

  // Advance items carry random coordinates, which the block must ignore.
  function automatic line_in_t advance_item();
    line_in_t item;
    item.operation = OP_ADVANCE;
    item.start_x = 16'($urandom);
    item.start_y = 16'($urandom);
    item.end_x = 16'($urandom);
    item.end_y = 16'($urandom);
    return item;
  endfunction

  function automatic int near_coord(input int c);
    int off;
    int v;
    off = $urandom_range(0, 24);
    if ($urandom_range(0, 1) == 1) off = -off;
    v = c + off;
    if (v < 0 || v > 65535) v = c - off;
    return v;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Wait for all expected pixels, then let an idle advance still in flight clear the block.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_color(input logic [ColorWidth-1:0] value);
    int unsigned writes_before;
    writes_before = cfg_writes;
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(negedge clk_i); while (cfg_writes == writes_before);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_lines(input int n_items);
    int sent, kind, sx, sy, ex, ey, adx, ady, full, adv;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      sx = $urandom_range(0, 65535);
      sy = $urandom_range(0, 65535);
      if (kind < 75) begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else if (kind < 90) begin
        ex = $urandom_range(0, 65535);
        ey = $urandom_range(0, 65535);
      end else if (kind < 95) begin
        sx = extreme_coord();
        ex = extreme_coord();
        ey = sy;
      end else begin
        sy = extreme_coord();
        ey = extreme_coord();
        ex = sx;
      end
      send_item(start_item(16'(sx), 16'(sy), 16'(ex), 16'(ey)));
      sent++;
      adx = (ex > sx) ? ex - sx : sx - ex;
      ady = (ey > sy) ? ey - sy : sy - ey;
      full = ((adx > ady) ? adx : ady) + 1;
      kind = $urandom_range(0, 99);
      if (full > MaxAdvances) begin
        // Long lines are cut short and restarted by the next start item.
        adv = $urandom_range(0, MaxAdvances);
      end else if (kind < 80) begin
        adv = full;
      end else if (kind < 90) begin
        adv = $urandom_range(0, full - 1);
      end else begin
        adv = full + $urandom_range(1, 3);
      end
      for (int i = 0; i < adv; i++) begin
        send_item(advance_item());
        if (i < full) sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    send_item(start_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF) ^ {1'b1, 64'h0});
    send_item(start_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(advance_item());
    send_item(advance_item());
    drain_block();
  endtask

  task automatic test_directed_lines();
    write_color(32'hFFFF_FFFF);
    send_item(start_item(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    repeat (2) send_item(advance_item());
    // A new start drops the diagonal that is still in progress.
    send_item(start_item(16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
    repeat (2) send_item(advance_item());
    send_item(start_item(16'd10, 16'd20, 16'd13, 16'd12));
    repeat (10) send_item(advance_item());
    send_item(start_item(16'd5, 16'd5, 16'd5, 16'd9));
    repeat (5) send_item(advance_item());
    drain_block();
  endtask

  task automatic test_random_phase(input logic [ColorWidth-1:0] color, input int idle,
                                   input int stall, input int n_items);
    write_color(color);
    send_idle_pct = idle;
    stall_pct = stall;
    run_random_lines(n_items);
    drain_block();
  endtask

  task automatic test_backpressure();
    write_color($urandom);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_request = 1'b1;
    @(negedge clk_i);
    run_random_lines(200);
    drain_block();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_directed_lines();
    test_random_phase($urandom, 0, 0, 400);
    test_random_phase(32'h0000_0000, 76, 0, 300);
    test_random_phase(32'hFFFF_FFFF, 0, 76, 300);
    test_random_phase($urandom, 33, 33, 300);
    test_backpressure();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lpg_pkg.sv
rtl/core/lpg_in_stage.sv
rtl/core/lpg_step.sv
rtl/core/lpg_out_stage.sv
rtl/core/line_point_generator_core.sv
tb/sv/line_point_generator_core_tb.sv
